[sv/ple_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine package
// Sizes, codes and shared types for the list engine: cell chain control,
// result status codes and the bundle of extremes from the reduction tree.
// ----------------------------------------------------------------------------
package ple_pkg;

   // Sizes of the list.
   localparam int CAPACITY    = 16;
   localparam int VALUE_BITS  = 32;
   localparam int POS_BITS    = $clog2(CAPACITY);
   localparam int COUNT_BITS  = $clog2(CAPACITY + 1);
   localparam int REQ_POS_BITS = 8;

   // Reduction tree over the cells, padded to a power of two.
   localparam int LEVELS      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int TREE_SIZE   = 1 << LEVELS;
   localparam int RED_BITS    = $clog2(LEVELS + 1);

   localparam logic [COUNT_BITS-1:0] CAP_COUNT = COUNT_BITS'(CAPACITY);
   localparam logic [RED_BITS-1:0]   RED_LAST  = RED_BITS'(LEVELS);

   // Request opcodes.
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2
   } op_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_DONE     = 3'd0,
      ST_BADPOS   = 3'd1,
      ST_FULL     = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   // What one cell loads at the next edge.
   typedef enum logic [1:0] {
      SH_HOLD       = 2'd0,
      SH_LOAD       = 2'd1,
      SH_FROM_LOWER = 2'd2,
      SH_FROM_UPPER = 2'd3
   } shift_type;

   // Control sequencer states.
   typedef enum logic {
      S_IDLE   = 1'b0,
      S_REDUCE = 1'b1
   } state_type;

   // Extremes as they leave the reduction tree.
   typedef struct packed {
      logic                          valid;
      logic signed [VALUE_BITS-1:0]  hi;
      logic signed [VALUE_BITS-1:0]  lo;
   } extremes_type;

endpackage

[sv/ple_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// List cell
// Holds one list entry, takes a new value or a neighbor's value on command,
// and compares its entry against the search key.
// ----------------------------------------------------------------------------
module ple_cell (
   input  logic                                  clock,
   input  ple_pkg::shift_type                    ctrl,
   input  logic signed [ple_pkg::VALUE_BITS-1:0] load_value,
   input  logic signed [ple_pkg::VALUE_BITS-1:0] lower_value,
   input  logic signed [ple_pkg::VALUE_BITS-1:0] upper_value,
   input  logic signed [ple_pkg::VALUE_BITS-1:0] key,
   output logic signed [ple_pkg::VALUE_BITS-1:0] value_q,
   output logic                                  match
);

   logic signed [ple_pkg::VALUE_BITS-1:0] value_ff;
   logic signed [ple_pkg::VALUE_BITS-1:0] value_in;

   // Select the next entry: hold, new word, or shift from a neighbor.
   always_comb begin
      unique case (ctrl)
         ple_pkg::SH_LOAD:       value_in = load_value;
         ple_pkg::SH_FROM_LOWER: value_in = lower_value;
         ple_pkg::SH_FROM_UPPER: value_in = upper_value;
         default:                value_in = value_ff;
      endcase
   end

   // Entry register; its content is meaningless until written.
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_q = value_ff;
   assign match   = (value_ff == key);

endmodule

[sv/ple_minmax.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extremes reduction tree
// Registered binary tree that finds the largest and smallest occupied
// entries of the cell chain, one tree level per cycle.
// ----------------------------------------------------------------------------
module ple_minmax (
   input  logic                                  clock,
   input  logic [ple_pkg::COUNT_BITS-1:0]        count,
   input  logic signed [ple_pkg::VALUE_BITS-1:0] cell_value [ple_pkg::CAPACITY],
   output ple_pkg::extremes_type                 extremes
);

   ple_pkg::extremes_type leaf [ple_pkg::TREE_SIZE];
   ple_pkg::extremes_type node_ff [ple_pkg::LEVELS][ple_pkg::TREE_SIZE/2];

   // Merge two partial results; an invalid side is ignored.
   function automatic ple_pkg::extremes_type merge(input ple_pkg::extremes_type a,
                                                   input ple_pkg::extremes_type b);
      ple_pkg::extremes_type r;
      if (a.valid && b.valid) begin
         r.valid = 1'b1;
         r.hi    = (a.hi < b.hi) ? b.hi : a.hi;
         r.lo    = (b.lo < a.lo) ? b.lo : a.lo;
      end else if (a.valid) begin
         r = a;
      end else begin
         r = b;
      end
      return r;
   endfunction

   // Leaves: occupied cells are valid, padding leaves never are.
   for (genvar i = 0; i < ple_pkg::TREE_SIZE; i++) begin : g_leaf
      if (i < ple_pkg::CAPACITY) begin : g_cell
         always_comb begin
            leaf[i].valid = (int'(count) > i);
            leaf[i].hi    = cell_value[i];
            leaf[i].lo    = cell_value[i];
         end
      end else begin : g_pad
         always_comb begin
            leaf[i] = '0;
         end
      end
   end

   // Tree levels, each one register stage.
   for (genvar l = 1; l <= ple_pkg::LEVELS; l++) begin : g_level
      for (genvar j = 0; j < (ple_pkg::TREE_SIZE >> l); j++) begin : g_node
         if (l == 1) begin : g_first
            always_ff @(posedge clock) begin
               node_ff[0][j] <= merge(leaf[2*j], leaf[2*j+1]);
            end
         end else begin : g_upper
            always_ff @(posedge clock) begin
               node_ff[l-1][j] <= merge(node_ff[l-2][2*j], node_ff[l-2][2*j+1]);
            end
         end
      end
   end

   // An empty list reports zero for both extremes.
   always_comb begin
      extremes = node_ff[ple_pkg::LEVELS-1][0];
      if (!extremes.valid) begin
         extremes.hi = '0;
         extremes.lo = '0;
      end
   end

endmodule

[sv/positional_list_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine
// Ordered list of signed words in a shifting chain of cells, with insert at
// a position, delete at a position, search for a key, and extremes reporting.
// ----------------------------------------------------------------------------
// Timing: the cell chain and the entry count update at the accept edge, the
// extremes tree then registers each of its levels in turn (log2 of the
// capacity), and the result word is loaded into the output register.
// A new request is taken only after that load, which a receiver stall can hold.
// Reset clears the entry count and the handshake state; cells are not reset.
// ----------------------------------------------------------------------------
module positional_list_engine (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_opcode,
   input  logic [ple_pkg::REQ_POS_BITS-1:0]      req_position,
   input  logic signed [ple_pkg::VALUE_BITS-1:0] req_value,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [2:0]                            rsp_status,
   output logic [ple_pkg::POS_BITS-1:0]          rsp_found_position,
   output logic [ple_pkg::COUNT_BITS-1:0]        rsp_entry_count,
   output logic signed [ple_pkg::VALUE_BITS-1:0] rsp_largest,
   output logic signed [ple_pkg::VALUE_BITS-1:0] rsp_smallest,
   output logic                                  rsp_extremes_valid
);

   ple_pkg::state_type                    state_ff, state_in;
   logic [ple_pkg::RED_BITS-1:0]          red_cnt_ff, red_cnt_in;
   logic [ple_pkg::COUNT_BITS-1:0]        count_ff, count_in;
   ple_pkg::status_type                   status_ff, status_in;
   logic [ple_pkg::POS_BITS-1:0]          found_ff, found_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   ple_pkg::status_type                   rsp_status_ff;
   logic [ple_pkg::POS_BITS-1:0]          rsp_found_ff;
   logic [ple_pkg::COUNT_BITS-1:0]        rsp_count_ff;
   ple_pkg::extremes_type                 rsp_ext_ff;

   logic                                  accept;
   logic                                  out_free;
   logic                                  load_rsp;
   logic                                  insert_ok;
   logic                                  delete_ok;
   logic [ple_pkg::REQ_POS_BITS-1:0]      ins_pos;
   logic [ple_pkg::REQ_POS_BITS-1:0]      count_wide;
   logic                                  any_match;

   ple_pkg::shift_type                    cell_ctrl [ple_pkg::CAPACITY];
   logic signed [ple_pkg::VALUE_BITS-1:0] cell_value [ple_pkg::CAPACITY];
   logic [ple_pkg::CAPACITY-1:0]          cell_match;
   ple_pkg::extremes_type                 extremes;

   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign count_wide = ple_pkg::REQ_POS_BITS'(count_ff);

   // Decode the request against the current count.
   always_comb begin
      insert_ok = 1'b0;
      delete_ok = 1'b0;
      status_in = ple_pkg::ST_DONE;
      count_in  = count_ff;
      ins_pos   = req_position;
      unique case (req_opcode)
         ple_pkg::OP_INSERT: begin
            if (count_ff == '0) begin
               insert_ok = 1'b1;
               ins_pos   = '0;
            end else if (req_position > count_wide) begin
               status_in = ple_pkg::ST_BADPOS;
            end else if (count_ff >= ple_pkg::CAP_COUNT) begin
               status_in = ple_pkg::ST_FULL;
            end else begin
               insert_ok = 1'b1;
            end
            if (insert_ok) begin
               count_in = count_ff + 1'b1;
            end
         end
         ple_pkg::OP_DELETE: begin
            if (count_ff == '0) begin
               status_in = ple_pkg::ST_EMPTY;
            end else if (req_position >= count_wide) begin
               status_in = ple_pkg::ST_BADPOS;
            end else begin
               delete_ok = 1'b1;
               count_in  = count_ff - 1'b1;
            end
         end
         ple_pkg::OP_SEARCH: begin
            status_in = any_match ? ple_pkg::ST_DONE : ple_pkg::ST_NOTFOUND;
         end
         default: begin
            status_in = ple_pkg::ST_DONE;
         end
      endcase
   end

   // First occupied cell that matches the key.
   always_comb begin
      any_match = 1'b0;
      found_in  = '0;
      for (int i = ple_pkg::CAPACITY - 1; i >= 0; i--) begin
         if (cell_match[i] && (int'(count_ff) > i)) begin
            any_match = 1'b1;
            found_in  = i[ple_pkg::POS_BITS-1:0];
         end
      end
      if (req_opcode != ple_pkg::OP_SEARCH) begin
         found_in = '0;
      end
   end

   // Cell chain: per-cell shift control and neighbor wiring.
   for (genvar i = 0; i < ple_pkg::CAPACITY; i++) begin : g_cell
      always_comb begin
         cell_ctrl[i] = ple_pkg::SH_HOLD;
         if (accept && insert_ok) begin
            if (int'(ins_pos) == i) begin
               cell_ctrl[i] = ple_pkg::SH_LOAD;
            end else if (int'(ins_pos) < i) begin
               cell_ctrl[i] = ple_pkg::SH_FROM_LOWER;
            end
         end else if (accept && delete_ok) begin
            if ((int'(req_position) <= i) && (i < ple_pkg::CAPACITY - 1)) begin
               cell_ctrl[i] = ple_pkg::SH_FROM_UPPER;
            end
         end
      end

      ple_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl[i]),
         .load_value  (req_value),
         .lower_value (cell_value[(i > 0) ? i - 1 : i]),
         .upper_value (cell_value[(i < ple_pkg::CAPACITY - 1) ? i + 1 : i]),
         .key         (req_value),
         .value_q     (cell_value[i]),
         .match       (cell_match[i])
      );
   end

   ple_minmax u_minmax (
      .clock      (clock),
      .count      (count_ff),
      .cell_value (cell_value),
      .extremes   (extremes)
   );

   // Sequencer: accept in idle, wait out the tree, then hand off the word.
   always_comb begin
      state_in   = state_ff;
      red_cnt_in = red_cnt_ff;
      req_stall  = 1'b1;
      load_rsp   = 1'b0;
      unique case (state_ff)
         ple_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in   = ple_pkg::S_REDUCE;
               red_cnt_in = '0;
            end
         end
         ple_pkg::S_REDUCE: begin
            if (red_cnt_ff == ple_pkg::RED_LAST) begin
               if (out_free) begin
                  load_rsp = 1'b1;
                  state_in = ple_pkg::S_IDLE;
               end
            end else begin
               red_cnt_in = red_cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ple_pkg::S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ple_pkg::S_IDLE;
         red_cnt_ff <= '0;
         count_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         red_cnt_ff <= red_cnt_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // Per-request result fields held while the tree settles.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         found_ff  <= found_in;
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= found_ff;
         rsp_count_ff  <= count_ff;
         rsp_ext_ff    <= extremes;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_largest        = rsp_ext_ff.hi;
   assign rsp_smallest       = rsp_ext_ff.lo;
   assign rsp_extremes_valid = rsp_ext_ff.valid;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives insert, delete, search and unused-opcode request words into the list
// engine. It predicts each result word from its own copy of the list and
// compares every field in order. The run has a directed opening, then random
// phases with and without idling on either side. One phase holds off the
// receiver for a long stretch so the engine backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb;

   // The opcode that the engine treats as a no-op.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int RANDOM_PER_PHASE = 310;
   localparam int HOLD_LEN         = 300;
   localparam int TAIL_CYCLES      = 12;
   localparam int WATCHDOG_LIMIT   = 2000;

   typedef struct {
      logic [1:0]                            opcode;
      logic [ple_pkg::REQ_POS_BITS-1:0]      position;
      logic signed [ple_pkg::VALUE_BITS-1:0] value;
   } list_request_type;

   typedef struct {
      ple_pkg::status_type                   status;
      logic [ple_pkg::POS_BITS-1:0]          found;
      logic [ple_pkg::COUNT_BITS-1:0]        count;
      logic signed [ple_pkg::VALUE_BITS-1:0] largest;
      logic signed [ple_pkg::VALUE_BITS-1:0] smallest;
      logic                                  extremes_valid;
   } list_result_type;

   typedef struct {
      logic signed [ple_pkg::VALUE_BITS-1:0] cells [ple_pkg::CAPACITY];
      int                                    count;
   } list_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic [1:0]                            req_opcode = 2'd0;
   logic [ple_pkg::REQ_POS_BITS-1:0]      req_position = '0;
   logic signed [ple_pkg::VALUE_BITS-1:0] req_value = '0;

   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic [2:0]                            rsp_status;
   logic [ple_pkg::POS_BITS-1:0]          rsp_found_position;
   logic [ple_pkg::COUNT_BITS-1:0]        rsp_entry_count;
   logic signed [ple_pkg::VALUE_BITS-1:0] rsp_largest;
   logic signed [ple_pkg::VALUE_BITS-1:0] rsp_smallest;
   logic                                  rsp_extremes_valid;

   list_request_type pending_words [$];
   list_result_type  expected_results [$];

   // The list as the engine holds it, and the list as planned by stimulus.
   list_state_type engine_list;
   list_state_type planned_list;

   int  idle_pct = 0;
   int  stall_pct = 0;
   bit  pressure_on = 1'b0;
   bit  filling = 1'b1;
   int  hold_cycles;
   int  quiet_cycles;
   int  mismatches = 0;
   int  words_sent = 0;
   int  results_checked = 0;
   int  status_seen [8];

   positional_list_engine i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_largest        (rsp_largest),
      .rsp_smallest       (rsp_smallest),
      .rsp_extremes_valid (rsp_extremes_valid)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one request to a list and return the result word it produces.
   function automatic list_result_type list_apply(inout list_state_type lst,
                                                  input list_request_type r);
      list_result_type res;
      int n;
      int p;
      res.status = ple_pkg::ST_DONE;
      res.found = '0;
      n = lst.count;
      p = r.position;
      case (r.opcode)
         ple_pkg::OP_INSERT: begin
            if (n == 0) begin
               lst.cells[0] = r.value;
               n = 1;
            end else if (p > n) begin
               res.status = ple_pkg::ST_BADPOS;
            end else if (n >= ple_pkg::CAPACITY) begin
               res.status = ple_pkg::ST_FULL;
            end else begin
               for (int i = n; i > p; i--)
                  lst.cells[i] = lst.cells[i-1];
               lst.cells[p] = r.value;
               n++;
            end
         end
         ple_pkg::OP_DELETE: begin
            if (n == 0) begin
               res.status = ple_pkg::ST_EMPTY;
            end else if (p >= n) begin
               res.status = ple_pkg::ST_BADPOS;
            end else begin
               for (int i = p; i + 1 < n; i++)
                  lst.cells[i] = lst.cells[i+1];
               n--;
            end
         end
         ple_pkg::OP_SEARCH: begin
            res.status = ple_pkg::ST_NOTFOUND;
            for (int i = 0; i < n; i++) begin
               if (res.status == ple_pkg::ST_NOTFOUND && lst.cells[i] == r.value) begin
                  res.status = ple_pkg::ST_DONE;
                  res.found = ple_pkg::POS_BITS'(i);
               end
            end
         end
         default: ;
      endcase
      lst.count = n;

      // Extremes over the entries that remain.
      res.largest = '0;
      res.smallest = '0;
      if (n > 0) begin
         res.largest = lst.cells[0];
         res.smallest = lst.cells[0];
         for (int i = 1; i < n; i++) begin
            if (lst.cells[i] > res.largest)
               res.largest = lst.cells[i];
            if (lst.cells[i] < res.smallest)
               res.smallest = lst.cells[i];
         end
      end
      res.count = ple_pkg::COUNT_BITS'(n);
      res.extremes_valid = (n > 0);
      return res;
   endfunction

   // Queue a request word and advance the planned list past it.
   task automatic queue_request(input logic [1:0] op,
                                input logic [ple_pkg::REQ_POS_BITS-1:0] pos,
                                input logic signed [ple_pkg::VALUE_BITS-1:0] val);
      list_request_type r;
      r.opcode = op;
      r.position = pos;
      r.value = val;
      pending_words.push_back(r);
      void'(list_apply(planned_list, r));
   endtask

   // Values lean toward a small pool so that searches hit duplicates.
   function automatic logic signed [ple_pkg::VALUE_BITS-1:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 35)
         return ple_pkg::VALUE_BITS'(int'($urandom_range(8)) - 4);
      if (roll < 45) begin
         case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return ple_pkg::VALUE_BITS'($urandom);
   endfunction

   // Mostly well-formed requests against the planned list, with the list
   // swinging between empty and full, plus some requests with random fields.
   task automatic queue_random_request();
      int roll;
      int n;
      logic [1:0] op;
      logic [ple_pkg::REQ_POS_BITS-1:0] pos;
      logic signed [ple_pkg::VALUE_BITS-1:0] val;
      n = planned_list.count;
      if (n == ple_pkg::CAPACITY && $urandom_range(3) == 0)
         filling = 1'b0;
      if (n == 0 && $urandom_range(1) == 0)
         filling = 1'b1;
      if ($urandom_range(39) == 0)
         filling = !filling;
      roll = $urandom_range(99);
      val = pick_value();
      pos = ple_pkg::REQ_POS_BITS'($urandom);
      if (roll < 5) begin
         op = 2'($urandom);
         val = ple_pkg::VALUE_BITS'($urandom);
      end else if (roll < 8) begin
         op = OP_UNUSED;
      end else if (roll < 30) begin
         op = ple_pkg::OP_SEARCH;
         if (n > 0 && $urandom_range(2) != 0)
            val = planned_list.cells[$urandom_range(n - 1)];
      end else if ((roll < 80) == filling) begin
         op = ple_pkg::OP_INSERT;
         if ($urandom_range(9) != 0)
            pos = ple_pkg::REQ_POS_BITS'($urandom_range(n));
      end else begin
         op = ple_pkg::OP_DELETE;
         if (n > 0 && $urandom_range(9) != 0)
            pos = ple_pkg::REQ_POS_BITS'($urandom_range(n - 1));
      end
      queue_request(op, pos, val);
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic compare_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Request driver: predicts each accepted word, then offers the next one.
   always @(posedge clock) begin : drive_words
      list_request_type nxt;
      list_request_type taken;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            taken.opcode = req_opcode;
            taken.position = req_position;
            taken.value = req_value;
            expected_results.push_back(list_apply(engine_list, taken));
            words_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
               nxt = pending_words.pop_front();
               req_valid <= 1'b1;
               req_opcode <= nxt.opcode;
               req_position <= nxt.position;
               req_value <= nxt.value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: one long hold-off when pressure is asked for, else random stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cycles <= 0;
      end else if (pressure_on && hold_cycles < HOLD_LEN) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Result monitor: every accepted word is matched against the oldest prediction.
   always @(posedge clock) begin : check_results
      list_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         status_seen[rsp_status]++;
         if (expected_results.size() == 0) begin
            $error("result word arrived with no prediction waiting");
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            compare_field("status", want.status, rsp_status);
            compare_field("found_position", want.found, rsp_found_position);
            compare_field("entry_count", want.count, rsp_entry_count);
            compare_field("largest", want.largest, rsp_largest);
            compare_field("smallest", want.smallest, rsp_smallest);
            compare_field("extremes_valid", want.extremes_valid, rsp_extremes_valid);
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("positional_list_engine test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      engine_list.count = 0;
      planned_list.count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening: empty-list cases, edge positions, filling to capacity.
      queue_request(ple_pkg::OP_SEARCH, 8'd0, 32'sd5);
      queue_request(ple_pkg::OP_DELETE, 8'd0, 32'sd0);
      queue_request(ple_pkg::OP_DELETE, 8'hFF, -32'sd1);
      queue_request(OP_UNUSED, 8'hAA, 32'h5555_5555);
      // An empty list takes any position.
      queue_request(ple_pkg::OP_INSERT, 8'hFF, 32'h7FFF_FFFF);
      queue_request(ple_pkg::OP_INSERT, 8'd2, 32'sd1);
      queue_request(ple_pkg::OP_INSERT, 8'd1, 32'h8000_0000);
      queue_request(ple_pkg::OP_INSERT, 8'd0, 32'sd0);
      queue_request(ple_pkg::OP_SEARCH, 8'd0, 32'h8000_0000);
      queue_request(ple_pkg::OP_DELETE, 8'd3, 32'sd0);
      for (int i = 0; i < 13; i++)
         queue_request(ple_pkg::OP_INSERT, ple_pkg::REQ_POS_BITS'(i % 4), i % 3 - 1);
      // Full list: a valid position reports full, a bad one reports bad position.
      queue_request(ple_pkg::OP_INSERT, 8'd16, 32'sd9);
      queue_request(ple_pkg::OP_INSERT, 8'd17, 32'sd9);
      queue_request(ple_pkg::OP_SEARCH, 8'd0, 32'sd1);
      queue_request(ple_pkg::OP_DELETE, 8'd15, 32'sd0);
      queue_request(ple_pkg::OP_DELETE, 8'd0, 32'sd0);
      wait_drained();

      // Random phases with different idling on each side.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 54; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 54; end
            3: begin idle_pct = 9;  stall_pct = 9;  end
            default: begin
               idle_pct = 0;
               stall_pct = 0;
               pressure_on = 1'b1;
            end
         endcase
         for (int k = 0; k < RANDOM_PER_PHASE; k++)
            queue_random_request();
         wait_drained();
      end
      pressure_on = 1'b0;

      repeat (TAIL_CYCLES) @(negedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d predicted result words never arrived", expected_results.size());
         mismatches++;
      end

      $display("Sent %0d request words and checked %0d result words.",
               words_sent, results_checked);
      $display("Outcomes: %0d done, %0d bad position, %0d full, %0d empty, %0d not found.",
               status_seen[ple_pkg::ST_DONE], status_seen[ple_pkg::ST_BADPOS],
               status_seen[ple_pkg::ST_FULL], status_seen[ple_pkg::ST_EMPTY],
               status_seen[ple_pkg::ST_NOTFOUND]);
      if (mismatches == 0) begin
         $display("positional_list_engine test passed");
      end else begin
         $display("positional_list_engine test failed");
      end
      $finish;
   end

endmodule
